/* rtl/core/crc32d_pkg.sv */
// Shared types, constants and the byte-wide CRC-32 update for the datagram checker.
`default_nettype none

package crc32d_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;
  localparam logic [7:0]  SepByte = 8'hFF;
  localparam logic [7:0]  AsciiZero = 8'h30;
  localparam logic [7:0]  AsciiNine = 8'h39;

  typedef enum logic [1:0] {
    PH_MSG   = 2'd0,
    PH_FIELD = 2'd1,
    PH_TAIL  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        frame_ok;
    logic        separator_seen;
    logic [31:0] computed_crc;
    logic [31:0] received_value;
    logic        value_valid;
  } out_item_t;

  // Reflected CRC-32, one byte folded in as eight shift/xor steps.
  function automatic logic [31:0] crc32d_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h00_0000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/crc32_datagram_checker.sv */
// Top level of the CRC-32 datagram checker: byte intake and result register.
`default_nettype none

// The checker takes a datagram one byte per item, with last_byte marking the
// final byte. Bytes up to the first 0xFF form the message and are run through
// the reflected CRC-32 (poly 0xEDB88320, init and final xor all ones); bytes
// between the first and second 0xFF are read as an unsigned decimal number,
// anything after the second 0xFF is ignored. Each item is folded into the
// running state in the cycle it is accepted, so one byte is taken every clock
// while intake is not stalled; the byte-wide CRC update plus the 32-bit
// compare is the longest path. One result item appears on the cycle after the
// last byte is accepted, and the per-datagram state clears at the same edge,
// so the next datagram can start straight away. A waiting result holds input
// intake only while the output side stalls it.
module crc32_datagram_checker import crc32d_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic      in_accept;
  out_item_t result;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  // Only a stalled pending result blocks the input; taking it frees the slot
  // in the same cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  crc32d_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_item_i),
    .result_o (result)
  );

  always_comb begin
    if (in_accept && in_item_i.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: no reset needed, loaded only with a fresh result
  always_ff @(posedge clk_i) begin
    if (in_accept && in_item_i.last_byte) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // An accepted last byte always yields a result next cycle.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.last_byte) |=> out_valid_o)
    else $error("last byte accepted without a result");

  // A match is only claimed when a separator was seen.
  a_ok_needs_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_item_o.frame_ok || out_item_o.separator_seen))
    else $error("frame_ok without separator");

  // An invalid field reads as zero.
  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.value_valid) |-> (out_item_o.received_value == 32'h0))
    else $error("invalid field with nonzero value");

  // Intake is held only behind a pending result.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");
`endif

endmodule

`default_nettype wire

/* rtl/core/crc32d_parser.sv */
// Per-datagram state: field phase, running CRC and decimal field accumulator.
`default_nettype none

module crc32d_parser import crc32d_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire in_item_t  item_i,
  output out_item_t      result_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] acc_q, acc_d;
  logic        inv_q, inv_d;
  logic        digit_q, digit_d;

  logic        is_sep;
  logic        is_digit;
  logic [35:0] acc_next;
  logic [31:0] crc_fin;
  logic        sep;
  logic        valid;
  logic [31:0] recv;

  assign is_sep   = (item_i.data_byte == SepByte);
  assign is_digit = (item_i.data_byte >= AsciiZero) && (item_i.data_byte <= AsciiNine);
  // acc * 10 + digit, as two shifts and two adds
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + {32'h0000_0000, item_i.data_byte[3:0]};

  always_comb begin
    phase_d = phase_q;
    crc_d   = crc_q;
    acc_d   = acc_q;
    inv_d   = inv_q;
    digit_d = digit_q;
    case (phase_q)
      PH_MSG: begin
        if (is_sep) begin
          phase_d = PH_FIELD;
        end else begin
          crc_d = crc32d_byte(crc_q, item_i.data_byte);
        end
      end
      PH_FIELD: begin
        if (is_sep) begin
          phase_d = PH_TAIL;
        end else if (is_digit) begin
          digit_d = 1'b1;
          acc_d   = acc_next[31:0];
          if (acc_next[35:32] != 4'h0) begin
            inv_d = 1'b1;
          end
        end else begin
          inv_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign crc_fin = crc_d ^ CrcOnes;
  assign sep     = (phase_d != PH_MSG);
  assign valid   = sep && digit_d && !inv_d;
  assign recv    = valid ? acc_d : 32'h0000_0000;

  assign result_o.frame_ok       = sep && (recv == crc_fin);
  assign result_o.separator_seen = sep;
  assign result_o.computed_crc   = crc_fin;
  assign result_o.received_value = recv;
  assign result_o.value_valid    = valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MSG;
      crc_q   <= CrcOnes;
      acc_q   <= 32'h0000_0000;
      inv_q   <= 1'b0;
      digit_q <= 1'b0;
    end else if (accept_i) begin
      if (item_i.last_byte) begin
        phase_q <= PH_MSG;
        crc_q   <= CrcOnes;
        acc_q   <= 32'h0000_0000;
        inv_q   <= 1'b0;
        digit_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        crc_q   <= crc_d;
        acc_q   <= acc_d;
        inv_q   <= inv_d;
        digit_q <= digit_d;
      end
    end
  end

endmodule

`default_nettype wire

/* dv/crc32_datagram_checker_test.sv */
// Self-checking testbench for the CRC-32 datagram checker.
module crc32_datagram_checker_test;
  import crc32d_pkg::*;

  typedef logic [7:0] octet_queue_t[$];

  // Tracks each datagram as its bytes are accepted, works out the verdict that the
  // final byte should produce, and matches verdicts from the block in order.
  class datagram_verdicts;
    out_item_t   pending_verdicts[$];
    int          failures;
    phase_e      section;
    logic [31:0] crc_acc;
    logic [31:0] dec_acc;
    logic        bad_field;
    logic        got_digit;

    function new();
      failures = 0;
      clear_datagram();
    endfunction

    function void clear_datagram();
      section   = PH_MSG;
      crc_acc   = CrcOnes;
      dec_acc   = '0;
      bad_field = 1'b0;
      got_digit = 1'b0;
    endfunction

    // Bitwise reflected CRC-32: feedback is the low CRC bit xor the next data bit.
    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = {1'b0, c[31:1]} ^ (fb ? CrcPoly : 32'd0);
      end
      return c;
    endfunction

    function void note_byte(in_item_t it);
      logic [35:0] wide;
      out_item_t   v;
      case (section)
        PH_MSG: begin
          if (it.data_byte == SepByte) section = PH_FIELD;
          else crc_acc = crc_step(crc_acc, it.data_byte);
        end
        PH_FIELD: begin
          if (it.data_byte == SepByte) begin
            section = PH_TAIL;
          end else if (it.data_byte >= AsciiZero && it.data_byte <= AsciiNine) begin
            wide      = {4'd0, dec_acc} * 36'd10
                      + {28'd0, 8'(it.data_byte - AsciiZero)};
            got_digit = 1'b1;
            if (wide[35:32] != 4'd0) bad_field = 1'b1;
            dec_acc   = wide[31:0];
          end else begin
            bad_field = 1'b1;
          end
        end
        default: ;
      endcase
      if (!it.last_byte) return;
      v.computed_crc   = crc_acc ^ CrcOnes;
      v.separator_seen = (section != PH_MSG);
      v.value_valid    = v.separator_seen && got_digit && !bad_field;
      v.received_value = v.value_valid ? dec_acc : 32'd0;
      v.frame_ok       = v.separator_seen && (v.received_value == v.computed_crc);
      pending_verdicts.push_back(v);
      clear_datagram();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict with nothing expected, expected none, got %h", $time, got);
        failures++;
        return;
      end
      want = pending_verdicts.pop_front();
      compare_field("frame_ok", 32'(want.frame_ok), 32'(got.frame_ok));
      compare_field("separator_seen", 32'(want.separator_seen), 32'(got.separator_seen));
      compare_field("computed_crc", want.computed_crc, got.computed_crc);
      compare_field("received_value", want.received_value, got.received_value);
      compare_field("value_valid", 32'(want.value_valid), 32'(got.value_valid));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  in_item_t  in_item;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;

  // Bytes of the datagram being built, sent in one go by send_datagram.
  octet_queue_t dgram;

  datagram_verdicts board = new();

  crc32_datagram_checker u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Result side: sample at the edge (pre-edge values), then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_verdict(out_item);
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Offer one item; returns at the edge that accepted it. Idle cycles come first,
  // so valid is only ever dropped between items, never while one is held.
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(it);
    items_sent++;
  endtask

  task automatic send_datagram();
    foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1);
    dgram.delete();
  endtask

  // Random message bytes (never the separator); gives back their CRC.
  function automatic logic [31:0] push_message(int len);
    logic [31:0] c;
    logic [7:0]  b;
    c = CrcOnes;
    repeat (len) begin
      b = 8'($urandom_range(0, 254));
      dgram.push_back(b);
      c = datagram_verdicts::crc_step(c, b);
    end
    return c ^ CrcOnes;
  endfunction

  // ASCII decimal, most significant digit first; 64 bits so overflow can be sent.
  function automatic void push_decimal(logic [63:0] v);
    logic [63:0] p;
    p = 1;
    while (p <= v / 10) p = p * 10;
    while (p != 0) begin
      dgram.push_back(AsciiZero + 8'((v / p) % 10));
      p = p / 10;
    end
  endfunction

  // Half the time a second separator and some bytes the block must ignore.
  function automatic void push_tail();
    if ($urandom_range(0, 1) == 1) begin
      dgram.push_back(SepByte);
      repeat ($urandom_range(0, 3)) dgram.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void fill_random_datagram();
    int          pick;
    logic [31:0] crc;
    logic [63:0] val;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // well formed and matching, sometimes with leading zeros
      crc = push_message($urandom_range(0, 8));
      dgram.push_back(SepByte);
      repeat ($urandom_range(0, 2)) dgram.push_back(AsciiZero);
      push_decimal({32'd0, crc});
      push_tail();
    end else if (pick < 60) begin
      // well formed, wrong checksum: random value or one bit off
      crc = push_message($urandom_range(0, 8));
      dgram.push_back(SepByte);
      if ($urandom_range(0, 1) == 1) val = {32'd0, 32'($urandom)};
      else val = {32'd0, crc ^ (32'd1 << $urandom_range(0, 31))};
      push_decimal(val);
      push_tail();
    end else if (pick < 68) begin
      // around the 32-bit limit
      void'(push_message($urandom_range(0, 3)));
      dgram.push_back(SepByte);
      case ($urandom_range(0, 3))
        0: val = 64'hFFFF_FFFF;
        1: val = 64'h1_0000_0000;
        2: val = 64'h1_0000_0000 + 64'($urandom);
        default: val = {24'd0, 8'($urandom_range(1, 255)), 32'($urandom)};
      endcase
      push_decimal(val);
      push_tail();
    end else if (pick < 76) begin
      // digits broken by a sign, space or other non-digit
      void'(push_message($urandom_range(0, 4)));
      dgram.push_back(SepByte);
      repeat ($urandom_range(0, 3)) dgram.push_back(AsciiZero + 8'($urandom_range(0, 9)));
      do b = 8'($urandom_range(0, 254));
      while (b >= AsciiZero && b <= AsciiNine);
      dgram.push_back(b);
      repeat ($urandom_range(0, 3)) dgram.push_back(AsciiZero + 8'($urandom_range(0, 9)));
      push_tail();
    end else if (pick < 84) begin
      // no separator at all
      void'(push_message($urandom_range(1, 10)));
    end else if (pick < 92) begin
      // separator with an empty field
      void'(push_message($urandom_range(0, 4)));
      dgram.push_back(SepByte);
      push_tail();
    end else begin
      // raw noise
      repeat ($urandom_range(1, 12)) dgram.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic set_idling(input int stage);
    case (stage)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
      default: begin send_idle_pct = 8; recv_stall_pct = 8; end
    endcase
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    out_stall <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed datagrams, no idling.
    // single byte, no separator
    dgram.push_back(8'h00);
    send_datagram();
    // lone separator: empty message gives CRC 0, empty field reads as 0, so it passes
    dgram.push_back(SepByte);
    send_datagram();
    // correct checksum followed by an ignored tail
    dgram.push_back(8'h41);
    dgram.push_back(SepByte);
    push_decimal({32'd0, datagram_verdicts::crc_step(CrcOnes, 8'h41) ^ CrcOnes});
    dgram.push_back(SepByte);
    dgram.push_back(8'h80);
    send_datagram();
    // a sign makes the field invalid
    dgram = '{8'h7F, SepByte, 8'h2B, 8'h37};
    send_datagram();
    // leading zeros, value 0 against empty-message CRC
    dgram = '{SepByte, AsciiZero, AsciiZero};
    send_datagram();

    // Random datagrams across four idling regimes.
    while (items_sent < 1800) begin
      set_idling((items_sent * 4) / 1800);
      fill_random_datagram();
      send_datagram();
    end
    in_valid <= 1'b0;

    // Drain, then give any stray verdict time to show up.
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (board.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/crc32d_pkg.sv
rtl/core/crc32d_parser.sv
rtl/core/crc32_datagram_checker.sv
dv/crc32_datagram_checker_test.sv
